FILE: hw/rtl/dwpw_pkg.sv
// Shared types and constants of the display window pixel writer.
// Item, result and queue entry layouts, command and register codes.
// No dependencies.
package dwpw_pkg;

  // Default screen size.
  localparam int SCREEN_COLUMNS_DEF = 240;
  localparam int SCREEN_ROWS_DEF    = 240;

  // Depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_X_START = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_X_END   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_START = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_END   = 4'd3;

  // Command codes of an input word.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Memory operation decided by the front part.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_FILL,
    OP_READ
  } op_t;

  // One input word.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] pixel_value;
    logic        burst_end;
    logic [7:0]  read_column;
    logic [7:0]  read_row;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [15:0] read_pixel;
    logic [7:0]  cursor_column;
    logic [7:0]  cursor_row;
    logic        window_wrapped;
    logic        pixel_dropped;
  } result_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    op_t         op;
    logic [15:0] pixel;
    logic [7:0]  cursor_column;
    logic [7:0]  cursor_row;
    logic        window_wrapped;
    logic        pixel_dropped;
  } info_t;

endpackage

FILE: hw/rtl/dwpw_front.sv
// Front part of the display window pixel writer: window registers, cursor
// and burst overrun tracking, command classification and address forming.
// Depends on dwpw_pkg.
module dwpw_front #(
  parameter int SCREEN_COLUMNS = 240,
  parameter int SCREEN_ROWS    = 240,
  parameter int ADDR_W         = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dwpw_pkg::item_t                      in_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dwpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dwpw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 busy,
  input  logic                                 push_ready,
  output logic                                 push,
  output logic [ADDR_W-1:0]                    push_addr,
  output dwpw_pkg::info_t                      push_info
);
  import dwpw_pkg::*;

  localparam int XW = ($clog2(SCREEN_COLUMNS) > 8) ? $clog2(SCREEN_COLUMNS) : 8;
  localparam int YW = ($clog2(SCREEN_ROWS) > 8) ? $clog2(SCREEN_ROWS) : 8;

  logic [XW-1:0] x_start, x_end;
  logic [YW-1:0] y_start, y_end;
  logic [XW-1:0] cursor_x, cursor_x_next;
  logic [YW-1:0] cursor_y, cursor_y_next;
  logic          overrun, overrun_next;

  logic          accept;
  logic          cfg_write;
  logic          cfg_known;
  logic [XW-1:0] cfg_sat_x;
  logic [YW-1:0] cfg_sat_y;
  logic [XW-1:0] x_start_new;
  logic [YW-1:0] y_start_new;
  logic [XW:0]   step_x;
  logic [YW:0]   step_y;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = push_ready && !busy;
  assign accept    = in_valid && in_ready;
  assign push      = accept;

  // Saturate a written window bound to the last column or row.
  assign cfg_sat_x = (int'(cfg_data) > SCREEN_COLUMNS - 1) ? XW'(SCREEN_COLUMNS - 1)
                                                            : XW'(cfg_data);
  assign cfg_sat_y = (int'(cfg_data) > SCREEN_ROWS - 1) ? YW'(SCREEN_ROWS - 1)
                                                         : YW'(cfg_data);
  assign cfg_known = (cfg_index == REG_X_START) || (cfg_index == REG_X_END) ||
                     (cfg_index == REG_Y_START) || (cfg_index == REG_Y_END);
  assign x_start_new = (cfg_index == REG_X_START) ? cfg_sat_x : x_start;
  assign y_start_new = (cfg_index == REG_Y_START) ? cfg_sat_y : y_start;

  // Classify the word and step the cursor through the window.
  always_comb begin
    push_info                = '0;
    push_info.op             = OP_NONE;
    push_info.pixel          = in_data.pixel_value;
    push_addr                = '0;
    overrun_next             = overrun;
    step_x                   = {1'b0, cursor_x};
    step_y                   = {1'b0, cursor_y};
    case (in_data.cmd)
      CMD_WRITE: begin
        if (overrun) begin
          push_info.pixel_dropped = 1'b1;
          if (in_data.burst_end) begin
            overrun_next = 1'b0;
          end
        end else begin
          if ((int'(cursor_x) < SCREEN_COLUMNS) && (int'(cursor_y) < SCREEN_ROWS)) begin
            push_info.op = OP_WRITE;
            push_addr    = ADDR_W'(cursor_y) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(cursor_x);
          end
          step_x = {1'b0, cursor_x} + 1'b1;
          if (step_x > {1'b0, x_end}) begin
            step_x = {1'b0, x_start};
            step_y = {1'b0, cursor_y} + 1'b1;
          end
          if (step_y > {1'b0, y_end}) begin
            step_y                   = {1'b0, y_start};
            push_info.window_wrapped = 1'b1;
            if (!in_data.burst_end) begin
              overrun_next = 1'b1;
            end
          end
        end
      end
      CMD_FILL: begin
        push_info.op = OP_FILL;
      end
      CMD_READ: begin
        if ((int'(in_data.read_column) < SCREEN_COLUMNS) &&
            (int'(in_data.read_row) < SCREEN_ROWS)) begin
          push_info.op = OP_READ;
          push_addr    = ADDR_W'(in_data.read_row) * ADDR_W'(SCREEN_COLUMNS) +
                         ADDR_W'(in_data.read_column);
        end
      end
      default: begin
        push_info.op = OP_NONE;
      end
    endcase
    cursor_x_next           = step_x[XW-1:0];
    cursor_y_next           = step_y[YW-1:0];
    push_info.cursor_column = cursor_x_next[7:0];
    push_info.cursor_row    = cursor_y_next[7:0];
  end

  // Window registers, cursor and overrun flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_start  <= '0;
      x_end    <= XW'(SCREEN_COLUMNS - 1);
      y_start  <= '0;
      y_end    <= YW'(SCREEN_ROWS - 1);
      cursor_x <= '0;
      cursor_y <= '0;
      overrun  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_START: x_start <= cfg_sat_x;
        REG_X_END:   x_end   <= cfg_sat_x;
        REG_Y_START: y_start <= cfg_sat_y;
        REG_Y_END:   y_end   <= cfg_sat_y;
        default:     x_start <= x_start;
      endcase
      if (cfg_known) begin
        cursor_x <= x_start_new;
        cursor_y <= y_start_new;
        overrun  <= 1'b0;
      end
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      overrun  <= overrun_next;
    end
  end

endmodule

FILE: hw/rtl/dwpw_queue.sv
// Short first-in first-out queue between the front and the back part.
// Generic payload vector; no package dependencies.
module dwpw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The front part never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CNT_W'(DEPTH)))
    else $error("queue push while full");
`endif

endmodule

FILE: hw/rtl/dwpw_back.sv
// Back part of the display window pixel writer: frame memory, clearing and
// fill sweeps, pixel reads and the result register.
// Depends on dwpw_pkg.
module dwpw_back #(
  parameter int SCREEN_COLUMNS = 240,
  parameter int SCREEN_ROWS    = 240,
  parameter int ADDR_W         = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [ADDR_W-1:0] q_addr,
  input  dwpw_pkg::info_t   q_info,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output dwpw_pkg::result_t out_data
);
  import dwpw_pkg::*;

  localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_ROWS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FILL,
    ST_READ
  } state_t;

  logic [15:0]       mem [STORE_SIZE];
  logic [15:0]       rd_data;
  state_t            state;
  logic [ADDR_W-1:0] sweep_addr;
  logic [15:0]       fill_value;
  info_t             hold_info;

  logic              out_free;
  logic              sweeping;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [15:0]       mem_wdata;

  assign busy     = (state == ST_CLEAR);
  assign sweeping = (state == ST_CLEAR) || (state == ST_FILL);
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_RUN) && q_valid && out_free;

  assign mem_we    = sweeping || (q_pop && (q_info.op == OP_WRITE));
  assign mem_re    = q_pop && (q_info.op == OP_READ);
  assign mem_addr  = sweeping ? sweep_addr : q_addr;
  assign mem_wdata = sweeping ? fill_value : q_info.pixel;

  // Single-port frame memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_addr <= '0;
      fill_value <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR, ST_FILL: begin
          // The result word leaves when the receiver takes it.
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (sweep_addr == ADDR_W'(STORE_SIZE - 1)) begin
            sweep_addr <= '0;
            state      <= ST_RUN;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        ST_RUN: begin
          if (q_pop) begin
            hold_info               <= q_info;
            out_data.read_pixel     <= '0;
            out_data.cursor_column  <= q_info.cursor_column;
            out_data.cursor_row     <= q_info.cursor_row;
            out_data.window_wrapped <= q_info.window_wrapped;
            out_data.pixel_dropped  <= q_info.pixel_dropped;
            case (q_info.op)
              OP_READ: begin
                out_valid <= 1'b0;
                state     <= ST_READ;
              end
              OP_FILL: begin
                fill_value <= q_info.pixel;
                out_valid  <= 1'b1;
                state      <= ST_FILL;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_READ: begin
          out_data.read_pixel <= rd_data;
          out_valid           <= 1'b1;
          state               <= ST_RUN;
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Read data lands only in an empty result register.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !out_valid)
    else $error("result register busy when read data arrives");

  // A read returns to the run state in the next cycle and presents its word.
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> ((state == ST_RUN) && out_valid && (hold_info.op == OP_READ)))
    else $error("read did not complete");

  // Nothing is delivered before the clearing sweep has finished.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && !q_pop))
    else $error("activity during clearing sweep");
`endif

endmodule

FILE: hw/rtl/display_window_pixel_writer_core.sv
// Usage of the display window pixel writer core.
// Input channel (in_valid, in_ready, in_data): one command word per handshake:
//   pixel write at the cursor, fill of the whole screen, or pixel read.
// Output channel (out_valid, out_ready, out_data): exactly one result word for
//   each input word, in order.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): window
//   bounds, to be written by the user only while the block is idle (the block
//   itself does not enforce this); cfg_ready is always high.
// Flow: each accepted word passes the queue to the back part, whose result
//   word is registered; a read also waits for the registered read data.
//   Writes and no-op words sustain one word per cycle while the receiver
//   takes every result; a read or fill takes no new queue word until done.
//   A fill sweeps the whole memory; so does reset, with in_ready low meanwhile.
// When the receiver stalls, the result register holds its word and the queue
//   between the front and back parts keeps accepting until it is full.
// Depends on dwpw_pkg, dwpw_front, dwpw_queue and dwpw_back.
module display_window_pixel_writer_core #(
  parameter int SCREEN_COLUMNS = dwpw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = dwpw_pkg::SCREEN_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dwpw_pkg::item_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dwpw_pkg::result_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dwpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dwpw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dwpw_pkg::*;

  localparam int ADDR_W  = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);
  localparam int ENTRY_W = ADDR_W + $bits(info_t);

  logic              busy;
  logic              push, push_ready;
  logic [ADDR_W-1:0] push_addr;
  info_t             push_info;
  logic              q_valid, q_pop;
  logic [ENTRY_W-1:0] q_entry;
  logic [ADDR_W-1:0] q_addr;
  info_t             q_info;

  // Front part: window, cursor and classification.
  dwpw_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .push_ready(push_ready),
    .push      (push),
    .push_addr (push_addr),
    .push_info (push_info)
  );

  // Queue of classified commands.
  dwpw_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_addr, push_info}),
    .push_ready(push_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_entry)
  );

  assign q_addr = q_entry[ENTRY_W-1 -: ADDR_W];
  assign q_info = info_t'(q_entry[$bits(info_t)-1:0]);

  // Back part: frame memory and results.
  dwpw_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_addr   (q_addr),
    .q_info   (q_info),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
